@@ sv/pa2r_pkg.sv @@
// Package for the absolute-to-relative path command converter.
// Holds the command and result kind codes and the field widths.
// No dependencies.
package pa2r_pkg;

   localparam int KIND_IN_BITS  = 4;
   localparam int KIND_OUT_BITS = 3;

   typedef logic [KIND_IN_BITS-1:0]  cmd_kind_type;
   typedef logic [KIND_OUT_BITS-1:0] rel_kind_type;

   // absolute input kinds; anything above CMD_CLOSE is rejected
   localparam cmd_kind_type CMD_MOVE  = 4'd0;
   localparam cmd_kind_type CMD_LINE  = 4'd1;
   localparam cmd_kind_type CMD_QUAD  = 4'd2;
   localparam cmd_kind_type CMD_CUBIC = 4'd3;
   localparam cmd_kind_type CMD_CLOSE = 4'd4;

   localparam rel_kind_type REL_MOVE  = 3'd0;
   localparam rel_kind_type REL_LINE  = 3'd1;
   localparam rel_kind_type REL_QUAD  = 3'd2;
   localparam rel_kind_type REL_CUBIC = 3'd3;
   localparam rel_kind_type REL_CLOSE = 3'd4;

   // decoded result flags passed from the delta unit to the top level
   typedef struct packed {
      rel_kind_type rel_kind;
      logic         bad_input;
   } rsp_ctl_type;

endpackage

@@ sv/path_absolute_to_relative_unit.sv @@
// Top level of the absolute-to-relative path command converter.
// Input register, pen state and result register around pa2r_delta.
// Uses pa2r_pkg.
//
//   channel | prefix | direction | beat
//   --------+--------+-----------+---------------------------------------
//   request | req_   | in        | one absolute command
//   result  | rsp_   | out       | one relative command or error flag
//
// One beat per cycle sustained while rsp_stall stays low; an accepted
// request is loaded into the input register and then, once the result
// register is free, into the result register, where it shows as valid.
// The pen and subpath start update in the cycle a beat moves into the
// result register, so back-to-back commands see each other's pen.
// Reset is synchronous and clears pen, subpath start and both valid flags.
// A stalled result holds the result register; the input register still
// takes one more beat if it is empty, then req_stall rises.
module path_absolute_to_relative_unit #(
   parameter int COORD_BITS = 24
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_path_begin,
   input  pa2r_pkg::cmd_kind_type         req_cmd_kind,
   input  logic signed [COORD_BITS-1:0]   req_end_x,
   input  logic signed [COORD_BITS-1:0]   req_end_y,
   input  logic signed [COORD_BITS-1:0]   req_ctrl_a_x,
   input  logic signed [COORD_BITS-1:0]   req_ctrl_a_y,
   input  logic signed [COORD_BITS-1:0]   req_ctrl_b_x,
   input  logic signed [COORD_BITS-1:0]   req_ctrl_b_y,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output pa2r_pkg::rel_kind_type         rsp_rel_kind,
   output logic signed [COORD_BITS:0]     rsp_delta_end_x,
   output logic signed [COORD_BITS:0]     rsp_delta_end_y,
   output logic signed [COORD_BITS:0]     rsp_delta_ctrl_a_x,
   output logic signed [COORD_BITS:0]     rsp_delta_ctrl_a_y,
   output logic signed [COORD_BITS:0]     rsp_delta_ctrl_b_x,
   output logic signed [COORD_BITS:0]     rsp_delta_ctrl_b_y,
   output logic                           rsp_bad_input
);
   import pa2r_pkg::*;

   // input register
   logic                         s1_valid_ff;
   logic                         s1_begin_ff;
   cmd_kind_type                 s1_kind_ff;
   logic signed [COORD_BITS-1:0] s1_end_x_ff;
   logic signed [COORD_BITS-1:0] s1_end_y_ff;
   logic signed [COORD_BITS-1:0] s1_ctrl_a_x_ff;
   logic signed [COORD_BITS-1:0] s1_ctrl_a_y_ff;
   logic signed [COORD_BITS-1:0] s1_ctrl_b_x_ff;
   logic signed [COORD_BITS-1:0] s1_ctrl_b_y_ff;

   // pen state
   logic signed [COORD_BITS-1:0] pen_x_ff;
   logic signed [COORD_BITS-1:0] pen_y_ff;
   logic signed [COORD_BITS-1:0] start_x_ff;
   logic signed [COORD_BITS-1:0] start_y_ff;
   logic signed [COORD_BITS-1:0] pen_x_in;
   logic signed [COORD_BITS-1:0] pen_y_in;
   logic signed [COORD_BITS-1:0] start_x_in;
   logic signed [COORD_BITS-1:0] start_y_in;

   // result register
   logic                         rsp_valid_ff;
   rsp_ctl_type                  rsp_ctl_ff;
   rsp_ctl_type                  rsp_ctl_in;
   logic signed [COORD_BITS:0]   rsp_dex_ff;
   logic signed [COORD_BITS:0]   rsp_dey_ff;
   logic signed [COORD_BITS:0]   rsp_dax_ff;
   logic signed [COORD_BITS:0]   rsp_day_ff;
   logic signed [COORD_BITS:0]   rsp_dbx_ff;
   logic signed [COORD_BITS:0]   rsp_dby_ff;
   logic signed [COORD_BITS:0]   rsp_dex_in;
   logic signed [COORD_BITS:0]   rsp_dey_in;
   logic signed [COORD_BITS:0]   rsp_dax_in;
   logic signed [COORD_BITS:0]   rsp_day_in;
   logic signed [COORD_BITS:0]   rsp_dbx_in;
   logic signed [COORD_BITS:0]   rsp_dby_in;

   logic rsp_free;
   logic advance;
   logic req_take;

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && rsp_free;
   assign req_stall = s1_valid_ff && !rsp_free;
   assign req_take  = req_valid && !req_stall;

   pa2r_delta #(
      .COORD_BITS (COORD_BITS)
   ) u_delta (
      .path_begin     (s1_begin_ff),
      .cmd_kind       (s1_kind_ff),
      .end_x          (s1_end_x_ff),
      .end_y          (s1_end_y_ff),
      .ctrl_a_x       (s1_ctrl_a_x_ff),
      .ctrl_a_y       (s1_ctrl_a_y_ff),
      .ctrl_b_x       (s1_ctrl_b_x_ff),
      .ctrl_b_y       (s1_ctrl_b_y_ff),
      .pen_x          (pen_x_ff),
      .pen_y          (pen_y_ff),
      .start_x        (start_x_ff),
      .start_y        (start_y_ff),
      .ctl            (rsp_ctl_in),
      .delta_end_x    (rsp_dex_in),
      .delta_end_y    (rsp_dey_in),
      .delta_ctrl_a_x (rsp_dax_in),
      .delta_ctrl_a_y (rsp_day_in),
      .delta_ctrl_b_x (rsp_dbx_in),
      .delta_ctrl_b_y (rsp_dby_in),
      .pen_x_next     (pen_x_in),
      .pen_y_next     (pen_y_in),
      .start_x_next   (start_x_in),
      .start_y_next   (start_y_in)
   );

   // control and state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pen_x_ff     <= '0;
         pen_y_ff     <= '0;
         start_x_ff   <= '0;
         start_y_ff   <= '0;
      end else begin
         if (!req_stall) begin
            s1_valid_ff <= req_valid;
         end
         if (rsp_free) begin
            rsp_valid_ff <= s1_valid_ff;
         end
         if (advance) begin
            pen_x_ff   <= pen_x_in;
            pen_y_ff   <= pen_y_in;
            start_x_ff <= start_x_in;
            start_y_ff <= start_y_in;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_begin_ff    <= req_path_begin;
         s1_kind_ff     <= req_cmd_kind;
         s1_end_x_ff    <= req_end_x;
         s1_end_y_ff    <= req_end_y;
         s1_ctrl_a_x_ff <= req_ctrl_a_x;
         s1_ctrl_a_y_ff <= req_ctrl_a_y;
         s1_ctrl_b_x_ff <= req_ctrl_b_x;
         s1_ctrl_b_y_ff <= req_ctrl_b_y;
      end
      if (advance) begin
         rsp_ctl_ff <= rsp_ctl_in;
         rsp_dex_ff <= rsp_dex_in;
         rsp_dey_ff <= rsp_dey_in;
         rsp_dax_ff <= rsp_dax_in;
         rsp_day_ff <= rsp_day_in;
         rsp_dbx_ff <= rsp_dbx_in;
         rsp_dby_ff <= rsp_dby_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_rel_kind       = rsp_ctl_ff.rel_kind;
   assign rsp_bad_input      = rsp_ctl_ff.bad_input;
   assign rsp_delta_end_x    = rsp_dex_ff;
   assign rsp_delta_end_y    = rsp_dey_ff;
   assign rsp_delta_ctrl_a_x = rsp_dax_ff;
   assign rsp_delta_ctrl_a_y = rsp_day_ff;
   assign rsp_delta_ctrl_b_x = rsp_dbx_ff;
   assign rsp_delta_ctrl_b_y = rsp_dby_ff;

endmodule

@@ sv/pa2r_delta.sv @@
// Delta unit: subtracts the pen position from the command's points and
// computes the next pen and subpath start. Uses pa2r_pkg.
module pa2r_delta #(
   parameter int COORD_BITS = 24
) (
   input  logic                         path_begin,
   input  pa2r_pkg::cmd_kind_type       cmd_kind,
   input  logic signed [COORD_BITS-1:0] end_x,
   input  logic signed [COORD_BITS-1:0] end_y,
   input  logic signed [COORD_BITS-1:0] ctrl_a_x,
   input  logic signed [COORD_BITS-1:0] ctrl_a_y,
   input  logic signed [COORD_BITS-1:0] ctrl_b_x,
   input  logic signed [COORD_BITS-1:0] ctrl_b_y,
   input  logic signed [COORD_BITS-1:0] pen_x,
   input  logic signed [COORD_BITS-1:0] pen_y,
   input  logic signed [COORD_BITS-1:0] start_x,
   input  logic signed [COORD_BITS-1:0] start_y,
   output pa2r_pkg::rsp_ctl_type        ctl,
   output logic signed [COORD_BITS:0]   delta_end_x,
   output logic signed [COORD_BITS:0]   delta_end_y,
   output logic signed [COORD_BITS:0]   delta_ctrl_a_x,
   output logic signed [COORD_BITS:0]   delta_ctrl_a_y,
   output logic signed [COORD_BITS:0]   delta_ctrl_b_x,
   output logic signed [COORD_BITS:0]   delta_ctrl_b_y,
   output logic signed [COORD_BITS-1:0] pen_x_next,
   output logic signed [COORD_BITS-1:0] pen_y_next,
   output logic signed [COORD_BITS-1:0] start_x_next,
   output logic signed [COORD_BITS-1:0] start_y_next
);
   import pa2r_pkg::*;

   logic signed [COORD_BITS-1:0] pen_x_eff;
   logic signed [COORD_BITS-1:0] pen_y_eff;
   logic signed [COORD_BITS-1:0] start_x_eff;
   logic signed [COORD_BITS-1:0] start_y_eff;
   logic signed [COORD_BITS:0]   dex;
   logic signed [COORD_BITS:0]   dey;
   logic signed [COORD_BITS:0]   dax;
   logic signed [COORD_BITS:0]   day;
   logic signed [COORD_BITS:0]   dbx;
   logic signed [COORD_BITS:0]   dby;

   // path begin drops the pen and subpath start back to the origin
   assign pen_x_eff   = path_begin ? '0 : pen_x;
   assign pen_y_eff   = path_begin ? '0 : pen_y;
   assign start_x_eff = path_begin ? '0 : start_x;
   assign start_y_eff = path_begin ? '0 : start_y;

   assign dex = {end_x[COORD_BITS-1], end_x} - {pen_x_eff[COORD_BITS-1], pen_x_eff};
   assign dey = {end_y[COORD_BITS-1], end_y} - {pen_y_eff[COORD_BITS-1], pen_y_eff};
   assign dax = {ctrl_a_x[COORD_BITS-1], ctrl_a_x} - {pen_x_eff[COORD_BITS-1], pen_x_eff};
   assign day = {ctrl_a_y[COORD_BITS-1], ctrl_a_y} - {pen_y_eff[COORD_BITS-1], pen_y_eff};
   assign dbx = {ctrl_b_x[COORD_BITS-1], ctrl_b_x} - {pen_x_eff[COORD_BITS-1], pen_x_eff};
   assign dby = {ctrl_b_y[COORD_BITS-1], ctrl_b_y} - {pen_y_eff[COORD_BITS-1], pen_y_eff};

   always_comb begin
      ctl.rel_kind   = REL_MOVE;
      ctl.bad_input  = 1'b0;
      delta_end_x    = '0;
      delta_end_y    = '0;
      delta_ctrl_a_x = '0;
      delta_ctrl_a_y = '0;
      delta_ctrl_b_x = '0;
      delta_ctrl_b_y = '0;
      pen_x_next     = pen_x_eff;
      pen_y_next     = pen_y_eff;
      start_x_next   = start_x_eff;
      start_y_next   = start_y_eff;
      unique case (cmd_kind)
         CMD_MOVE: begin
            ctl.rel_kind = REL_MOVE;
            delta_end_x  = dex;
            delta_end_y  = dey;
            pen_x_next   = end_x;
            pen_y_next   = end_y;
            start_x_next = end_x;
            start_y_next = end_y;
         end
         CMD_LINE: begin
            ctl.rel_kind = REL_LINE;
            delta_end_x  = dex;
            delta_end_y  = dey;
            pen_x_next   = end_x;
            pen_y_next   = end_y;
         end
         CMD_QUAD: begin
            ctl.rel_kind   = REL_QUAD;
            delta_end_x    = dex;
            delta_end_y    = dey;
            delta_ctrl_a_x = dax;
            delta_ctrl_a_y = day;
            pen_x_next     = end_x;
            pen_y_next     = end_y;
         end
         CMD_CUBIC: begin
            ctl.rel_kind   = REL_CUBIC;
            delta_end_x    = dex;
            delta_end_y    = dey;
            delta_ctrl_a_x = dax;
            delta_ctrl_a_y = day;
            delta_ctrl_b_x = dbx;
            delta_ctrl_b_y = dby;
            pen_x_next     = end_x;
            pen_y_next     = end_y;
         end
         CMD_CLOSE: begin
            ctl.rel_kind = REL_CLOSE;
            pen_x_next   = start_x_eff;
            pen_y_next   = start_y_eff;
         end
         default: begin
            // relative or unknown kind: flag it and hold all state
            ctl.bad_input = 1'b1;
            pen_x_next    = pen_x;
            pen_y_next    = pen_y;
            start_x_next  = start_x;
            start_y_next  = start_y;
         end
      endcase
   end

endmodule

@@ tb/sv/path_tracker_pkg.sv @@
`timescale 1ns / 1ps
// Command and result beat types plus the pen-tracking scoreboard for the
// absolute-to-relative path converter testbench. Depends on pa2r_pkg.
package path_tracker_pkg;
   import pa2r_pkg::*;

   localparam int COORD_BITS = 24;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [COORD_BITS:0]   coord_delta_type;

   localparam coord_type COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam coord_type COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

   // relative kinds at the input are rejected, as is anything undefined
   localparam cmd_kind_type CMD_REL_FIRST = 4'd5;
   localparam cmd_kind_type CMD_REL_LAST  = 4'd8;
   localparam cmd_kind_type CMD_KIND_LAST = 4'd15;

   typedef struct packed {
      logic         path_begin;
      cmd_kind_type kind;
      coord_type    end_x;
      coord_type    end_y;
      coord_type    ctrl_a_x;
      coord_type    ctrl_a_y;
      coord_type    ctrl_b_x;
      coord_type    ctrl_b_y;
   } path_cmd_type;

   typedef struct packed {
      rel_kind_type    rel_kind;
      coord_delta_type d_end_x;
      coord_delta_type d_end_y;
      coord_delta_type d_ctrl_a_x;
      coord_delta_type d_ctrl_a_y;
      coord_delta_type d_ctrl_b_x;
      coord_delta_type d_ctrl_b_y;
      logic            bad_input;
   } rel_cmd_type;

   class rel_path_tracker;
      coord_type   pen_x = '0;
      coord_type   pen_y = '0;
      coord_type   start_x = '0;
      coord_type   start_y = '0;
      rel_cmd_type rel_cmd_q[$];
      int          mismatch_count = 0;

      static function coord_delta_type offset_from_pen(coord_type pos, coord_type pen);
         coord_delta_type wide_pos;
         coord_delta_type wide_pen;
         wide_pos = pos;
         wide_pen = pen;
         return wide_pos - wide_pen;
      endfunction

      function int pending();
         return rel_cmd_q.size();
      endfunction

      // Queue one expected beat at the tail.
      function void add_expected(rel_cmd_type r);
         rel_cmd_q = {rel_cmd_q, r};
      endfunction

      task report(string msg);
         $display("[%0t] mismatch: %s", $realtime, msg);
         mismatch_count++;
      endtask

      // Predict the relative beat for one accepted command and advance the pen.
      function void note_cmd(path_cmd_type c);
         rel_cmd_type r;
         r = '0;
         if (c.kind > CMD_CLOSE) begin
            r.bad_input = 1'b1;
            add_expected(r);
            return;
         end
         if (c.path_begin) begin
            pen_x = '0;
            pen_y = '0;
            start_x = '0;
            start_y = '0;
         end
         case (c.kind)
            CMD_MOVE:  r.rel_kind = REL_MOVE;
            CMD_LINE:  r.rel_kind = REL_LINE;
            CMD_QUAD:  r.rel_kind = REL_QUAD;
            CMD_CUBIC: r.rel_kind = REL_CUBIC;
            default:   r.rel_kind = REL_CLOSE;
         endcase
         if (c.kind == CMD_CLOSE) begin
            pen_x = start_x;
            pen_y = start_y;
         end else begin
            r.d_end_x = offset_from_pen(c.end_x, pen_x);
            r.d_end_y = offset_from_pen(c.end_y, pen_y);
            if (c.kind == CMD_QUAD || c.kind == CMD_CUBIC) begin
               r.d_ctrl_a_x = offset_from_pen(c.ctrl_a_x, pen_x);
               r.d_ctrl_a_y = offset_from_pen(c.ctrl_a_y, pen_y);
            end
            if (c.kind == CMD_CUBIC) begin
               r.d_ctrl_b_x = offset_from_pen(c.ctrl_b_x, pen_x);
               r.d_ctrl_b_y = offset_from_pen(c.ctrl_b_y, pen_y);
            end
            pen_x = c.end_x;
            pen_y = c.end_y;
            if (c.kind == CMD_MOVE) begin
               start_x = c.end_x;
               start_y = c.end_y;
            end
         end
         add_expected(r);
      endfunction

      task check_field(string name, longint got, longint want);
         if (got != want)
            report($sformatf("%s got %0d want %0d", name, got, want));
      endtask

      task check_result(rel_cmd_type got);
         rel_cmd_type want;
         if (rel_cmd_q.size() == 0) begin
            report("result beat with no command outstanding");
            return;
         end
         want = rel_cmd_q.pop_front();
         check_field("rel_kind", got.rel_kind, want.rel_kind);
         check_field("delta_end_x", got.d_end_x, want.d_end_x);
         check_field("delta_end_y", got.d_end_y, want.d_end_y);
         check_field("delta_ctrl_a_x", got.d_ctrl_a_x, want.d_ctrl_a_x);
         check_field("delta_ctrl_a_y", got.d_ctrl_a_y, want.d_ctrl_a_y);
         check_field("delta_ctrl_b_x", got.d_ctrl_b_x, want.d_ctrl_b_x);
         check_field("delta_ctrl_b_y", got.d_ctrl_b_y, want.d_ctrl_b_y);
         check_field("bad_input", got.bad_input, want.bad_input);
      endtask
   endclass

endpackage

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// Top of the testbench for path_absolute_to_relative_unit: directed and
// random path commands, random idling on both channels. Uses path_tracker_pkg.
module tb;
   import pa2r_pkg::*;
   import path_tracker_pkg::*;

   localparam int STALL_LIMIT = 2000;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   logic            req_path_begin = 1'b0;
   cmd_kind_type    req_cmd_kind = CMD_MOVE;
   coord_type       req_end_x = '0;
   coord_type       req_end_y = '0;
   coord_type       req_ctrl_a_x = '0;
   coord_type       req_ctrl_a_y = '0;
   coord_type       req_ctrl_b_x = '0;
   coord_type       req_ctrl_b_y = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rel_kind_type    rsp_rel_kind;
   coord_delta_type rsp_delta_end_x;
   coord_delta_type rsp_delta_end_y;
   coord_delta_type rsp_delta_ctrl_a_x;
   coord_delta_type rsp_delta_ctrl_a_y;
   coord_delta_type rsp_delta_ctrl_b_x;
   coord_delta_type rsp_delta_ctrl_b_y;
   logic            rsp_bad_input;

   rel_path_tracker tracker = new();

   int send_idle_pct = 22;
   int recv_idle_pct = 49;
   int send_quiet = 0;
   int recv_quiet = 0;
   int idle_cycles = 0;

   path_absolute_to_relative_unit #(.COORD_BITS(COORD_BITS)) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_path_begin     (req_path_begin),
      .req_cmd_kind       (req_cmd_kind),
      .req_end_x          (req_end_x),
      .req_end_y          (req_end_y),
      .req_ctrl_a_x       (req_ctrl_a_x),
      .req_ctrl_a_y       (req_ctrl_a_y),
      .req_ctrl_b_x       (req_ctrl_b_x),
      .req_ctrl_b_y       (req_ctrl_b_y),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_rel_kind       (rsp_rel_kind),
      .rsp_delta_end_x    (rsp_delta_end_x),
      .rsp_delta_end_y    (rsp_delta_end_y),
      .rsp_delta_ctrl_a_x (rsp_delta_ctrl_a_x),
      .rsp_delta_ctrl_a_y (rsp_delta_ctrl_a_y),
      .rsp_delta_ctrl_b_x (rsp_delta_ctrl_b_x),
      .rsp_delta_ctrl_b_y (rsp_delta_ctrl_b_y),
      .rsp_bad_input      (rsp_bad_input)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Sample both channels, drive the result stall, watch for a hang.
   always @(posedge clock) begin : monitor
      path_cmd_type seen;
      rel_cmd_type  got;
      logic         moved;
      moved = 1'b0;
      if (!reset && req_valid && !req_stall) begin
         seen.path_begin = req_path_begin;
         seen.kind       = req_cmd_kind;
         seen.end_x      = req_end_x;
         seen.end_y      = req_end_y;
         seen.ctrl_a_x   = req_ctrl_a_x;
         seen.ctrl_a_y   = req_ctrl_a_y;
         seen.ctrl_b_x   = req_ctrl_b_x;
         seen.ctrl_b_y   = req_ctrl_b_y;
         tracker.note_cmd(seen);
         moved = 1'b1;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         got.rel_kind   = rsp_rel_kind;
         got.d_end_x    = rsp_delta_end_x;
         got.d_end_y    = rsp_delta_end_y;
         got.d_ctrl_a_x = rsp_delta_ctrl_a_x;
         got.d_ctrl_a_y = rsp_delta_ctrl_a_y;
         got.d_ctrl_b_x = rsp_delta_ctrl_b_x;
         got.d_ctrl_b_y = rsp_delta_ctrl_b_y;
         got.bad_input  = rsp_bad_input;
         tracker.check_result(got);
         moved = 1'b1;
      end
      if (recv_quiet > 0) begin
         recv_quiet--;
         rsp_stall <= 1'b0;
      end else begin
         if ($urandom_range(0, 63) == 0)
            recv_quiet = 40;
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
      if (reset || moved)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic path_cmd_type make_cmd(logic pb, cmd_kind_type kind,
                                             coord_type ex, coord_type ey,
                                             coord_type ax, coord_type ay,
                                             coord_type bx, coord_type by);
      path_cmd_type c;
      c.path_begin = pb;
      c.kind       = kind;
      c.end_x      = ex;
      c.end_y      = ey;
      c.ctrl_a_x   = ax;
      c.ctrl_a_y   = ay;
      c.ctrl_b_x   = bx;
      c.ctrl_b_y   = by;
      return c;
   endfunction

   // Mix extremes, values near the origin and full-range noise.
   function automatic coord_type rand_coord();
      case ($urandom_range(0, 9))
         0: return COORD_MAX;
         1: return COORD_MIN;
         2: return '0;
         3, 4, 5: return coord_type'(int'($urandom_range(0, 511)) - 256);
         default: return coord_type'($urandom);
      endcase
   endfunction

   function automatic path_cmd_type rand_cmd(logic pb, cmd_kind_type kind);
      return make_cmd(pb, kind, rand_coord(), rand_coord(), rand_coord(),
                      rand_coord(), rand_coord(), rand_coord());
   endfunction

   task automatic send(path_cmd_type c);
      if (send_quiet > 0)
         send_quiet--;
      else if ($urandom_range(0, 63) == 0)
         send_quiet = 30;
      while (send_quiet == 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_path_begin <= c.path_begin;
      req_cmd_kind   <= c.kind;
      req_end_x      <= c.end_x;
      req_end_y      <= c.end_y;
      req_ctrl_a_x   <= c.ctrl_a_x;
      req_ctrl_a_y   <= c.ctrl_a_y;
      req_ctrl_b_x   <= c.ctrl_b_x;
      req_ctrl_b_y   <= c.ctrl_b_y;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   // Hold off new beats until every outstanding result is back.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0)
         @(posedge clock);
   endtask

   // Mostly well-formed subpaths, with a sprinkle of arbitrary commands.
   task automatic run_random(int n_items);
      int sent;
      int segs;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(0, 9) == 0) begin
            send(rand_cmd(1'($urandom_range(0, 1)),
                          cmd_kind_type'($urandom_range(0, CMD_KIND_LAST))));
            sent++;
         end else begin
            send(rand_cmd($urandom_range(0, 3) == 0, CMD_MOVE));
            sent++;
            segs = $urandom_range(1, 6);
            repeat (segs) begin
               send(rand_cmd($urandom_range(0, 15) == 0,
                             cmd_kind_type'($urandom_range(CMD_LINE, CMD_CUBIC))));
               sent++;
            end
            if ($urandom_range(0, 2) != 0) begin
               send(rand_cmd($urandom_range(0, 7) == 0, CMD_CLOSE));
               sent++;
            end
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // close before any move, then drive the pen across the full range
      send(make_cmd(1'b0, CMD_CLOSE, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN,
                    COORD_MAX, COORD_MIN));
      send(make_cmd(1'b1, CMD_MOVE, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN,
                    COORD_MIN, COORD_MIN));
      send(make_cmd(1'b0, CMD_LINE, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
                    COORD_MAX, COORD_MAX));
      send(make_cmd(1'b0, CMD_LINE, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN,
                    COORD_MIN, COORD_MIN));
      send(make_cmd(1'b0, CMD_QUAD, '0, '0, COORD_MIN, COORD_MAX,
                    COORD_MAX, COORD_MIN));
      send(make_cmd(1'b0, CMD_CUBIC, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN,
                    COORD_MIN, COORD_MAX));
      send(make_cmd(1'b0, CMD_CLOSE, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                    COORD_MIN, COORD_MIN));
      send(make_cmd(1'b0, CMD_CUBIC, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                    COORD_MIN, COORD_MIN));
      // relative and undefined kinds must leave the pen alone
      for (int k = CMD_REL_FIRST; k <= CMD_KIND_LAST; k++)
         send(rand_cmd(1'b1, cmd_kind_type'(k)));
      send(make_cmd(1'b0, CMD_LINE, coord_type'(1), coord_type'(-1), '0, '0, '0, '0));
      // path begin on a close leaves the pen at the origin
      send(make_cmd(1'b1, CMD_CLOSE, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                    COORD_MAX, COORD_MAX));
      send(rand_cmd(1'b0, CMD_QUAD));
      send(rand_cmd(1'b1, CMD_LINE));
      send(rand_cmd(1'b1, CMD_CUBIC));
      drain();

      run_random(430);
      drain();

      send_idle_pct = 49;
      recv_idle_pct = 22;
      run_random(430);
      drain();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(440);
      drain();

      repeat (4) @(posedge clock);
      if (tracker.pending() != 0)
         tracker.report($sformatf("%0d results never arrived", tracker.pending()));
      if (tracker.mismatch_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

@@ path_absolute_to_relative_unit.f @@
sv/pa2r_pkg.sv
sv/pa2r_delta.sv
sv/path_absolute_to_relative_unit.sv
tb/sv/path_tracker_pkg.sv
tb/sv/tb.sv
